### hdl/akscr_pkg.sv
`default_nettype none
package akscr_pkg;

	localparam int KeyLen = 16;
	localparam int Alpha  = 62;
	localparam int SubLen = 78;

	typedef logic [5:0] idx_t;
	typedef logic [6:0] pos_t;
	typedef idx_t [KeyLen-1:0] key_t;

	typedef struct packed {
		logic [63:0] key_in_high;
		logic [63:0] key_in_low;
	} in_t;

	typedef struct packed {
		logic [63:0] key_out_high;
		logic [63:0] key_out_low;
		logic        bad_character;
	} out_t;

	// payload carried between pipeline stages
	typedef struct packed {
		logic bad;
		key_t key;
	} stage_t;

	localparam logic [3:0] PERM_A [KeyLen] =
		'{4'd11, 4'd9, 4'd12, 4'd0, 4'd1, 4'd4, 4'd10, 4'd13,
		  4'd3, 4'd6, 4'd7, 4'd8, 4'd15, 4'd5, 4'd2, 4'd14};
	localparam logic [3:0] PERM_B [KeyLen] =
		'{4'd1, 4'd13, 4'd5, 4'd8, 4'd7, 4'd10, 4'd0, 4'd15,
		  4'd12, 4'd3, 4'd14, 4'd11, 4'd2, 4'd9, 4'd6, 4'd4};

	localparam idx_t SUB_A [SubLen] = '{
		6'd29, 6'd43, 6'd7,  6'd5,  6'd52, 6'd58, 6'd30, 6'd59,
		6'd26, 6'd35, 6'd35, 6'd49, 6'd45, 6'd4,  6'd22, 6'd4,
		6'd0,  6'd7,  6'd4,  6'd30, 6'd51, 6'd39, 6'd16, 6'd6,
		6'd32, 6'd13, 6'd40, 6'd44, 6'd14, 6'd58, 6'd27, 6'd41,
		6'd52, 6'd33, 6'd9,  6'd30, 6'd30, 6'd52, 6'd16, 6'd45,
		6'd43, 6'd18, 6'd27, 6'd52, 6'd40, 6'd52, 6'd10, 6'd8,
		6'd10, 6'd14, 6'd10, 6'd38, 6'd27, 6'd54, 6'd48, 6'd58,
		6'd17, 6'd34, 6'd6,  6'd29, 6'd53, 6'd39, 6'd31, 6'd35,
		6'd60, 6'd44, 6'd26, 6'd34, 6'd33, 6'd31, 6'd10, 6'd36,
		6'd51, 6'd44, 6'd39, 6'd53, 6'd5,  6'd56};

	localparam idx_t SUB_B [SubLen] = '{
		6'd7,  6'd32, 6'd25, 6'd39, 6'd22, 6'd26, 6'd32, 6'd27,
		6'd17, 6'd50, 6'd22, 6'd19, 6'd36, 6'd22, 6'd40, 6'd11,
		6'd41, 6'd10, 6'd10, 6'd2,  6'd10, 6'd8,  6'd44, 6'd40,
		6'd51, 6'd7,  6'd8,  6'd39, 6'd34, 6'd52, 6'd52, 6'd4,
		6'd56, 6'd61, 6'd59, 6'd26, 6'd22, 6'd15, 6'd17, 6'd9,
		6'd47, 6'd38, 6'd45, 6'd10, 6'd0,  6'd12, 6'd9,  6'd20,
		6'd51, 6'd59, 6'd32, 6'd58, 6'd19, 6'd28, 6'd11, 6'd40,
		6'd8,  6'd28, 6'd6,  6'd0,  6'd13, 6'd47, 6'd34, 6'd60,
		6'd4,  6'd56, 6'd21, 6'd60, 6'd59, 6'd16, 6'd38, 6'd52,
		6'd61, 6'd44, 6'd8,  6'd35, 6'd4,  6'd11};

	localparam idx_t SUB_C [SubLen] = '{
		6'd60, 6'd30, 6'd12, 6'd34, 6'd33, 6'd7,  6'd15, 6'd29,
		6'd16, 6'd20, 6'd46, 6'd25, 6'd8,  6'd31, 6'd4,  6'd48,
		6'd6,  6'd44, 6'd57, 6'd16, 6'd12, 6'd58, 6'd48, 6'd59,
		6'd21, 6'd32, 6'd2,  6'd18, 6'd51, 6'd8,  6'd50, 6'd29,
		6'd58, 6'd6,  6'd24, 6'd34, 6'd11, 6'd23, 6'd57, 6'd43,
		6'd59, 6'd50, 6'd10, 6'd56, 6'd27, 6'd32, 6'd12, 6'd59,
		6'd16, 6'd4,  6'd40, 6'd39, 6'd26, 6'd10, 6'd49, 6'd56,
		6'd51, 6'd60, 6'd21, 6'd37, 6'd12, 6'd56, 6'd39, 6'd15,
		6'd53, 6'd11, 6'd33, 6'd43, 6'd52, 6'd37, 6'd30, 6'd25,
		6'd19, 6'd55, 6'd7,  6'd34, 6'd48, 6'd36};

	// table offset: index (0..61) plus position (0..15) always stays below 78
	function automatic pos_t sub_pos(input idx_t v, input logic [3:0] i);
		return pos_t'(v) + pos_t'(i);
	endfunction

	// sum of two indexes is below 124, one conditional subtract suffices
	function automatic idx_t add_mod(input idx_t a, input idx_t b);
		logic [6:0] s;
		s = 7'(a) + 7'(b);
		return (s >= 7'(Alpha)) ? idx_t'(s - 7'(Alpha)) : idx_t'(s);
	endfunction

	function automatic logic char_bad(input logic [7:0] c);
		return (c < 8'd48) || (c > 8'd122);
	endfunction

	function automatic idx_t char_index(input logic [7:0] c);
		logic [7:0] d;
		if (char_bad(c)) begin
			d = 8'd0;
		end else if (c > 8'd90) begin
			d = c - 8'd61;
		end else if (c > 8'd57) begin
			d = c - 8'd55;
		end else begin
			d = c - 8'd48;
		end
		return d[5:0];
	endfunction

	function automatic logic [7:0] index_char(input idx_t d);
		logic [7:0] w;
		w = 8'(d);
		if (d >= 6'd36) begin
			return w + 8'd61;
		end else if (d >= 6'd10) begin
			return w + 8'd55;
		end
		return w + 8'd48;
	endfunction

endpackage
`default_nettype wire

### hdl/akscr_front.sv
`default_nettype none
// Stage 1: character decode and first substitution.
module akscr_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire akscr_pkg::in_t    in_data,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output akscr_pkg::stage_t      out_data
);

	logic              valid_s1;
	akscr_pkg::stage_t data_s1;
	akscr_pkg::stage_t next;
	logic [127:0]      chars;

	assign chars = {in_data.key_in_high, in_data.key_in_low};

	always_comb begin
		next.bad = 1'b0;
		next.key = '0;
		for (int i = 0; i < akscr_pkg::KeyLen; i++) begin
			next.bad = next.bad | akscr_pkg::char_bad(chars[8*i +: 8]);
			next.key[i] = akscr_pkg::SUB_A[akscr_pkg::sub_pos(
				akscr_pkg::char_index(chars[8*i +: 8]), 4'(i))];
		end
	end

	assign in_ready = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1 <= next;
		end
	end

	assign out_valid = valid_s1;
	assign out_data  = data_s1;

endmodule
`default_nettype wire

### hdl/akscr_mid.sv
`default_nettype none
// Stage 2: first permuted add, then second substitution.
module akscr_mid (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire akscr_pkg::stage_t   in_data,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output akscr_pkg::stage_t        out_data
);

	logic              valid_s2;
	akscr_pkg::stage_t data_s2;
	akscr_pkg::stage_t next;
	akscr_pkg::idx_t   mixed;

	always_comb begin
		next.bad = in_data.bad;
		next.key = '0;
		mixed    = '0;
		for (int i = 0; i < akscr_pkg::KeyLen; i++) begin
			mixed = akscr_pkg::add_mod(in_data.key[i],
				in_data.key[akscr_pkg::PERM_A[i]]);
			next.key[i] = akscr_pkg::SUB_B[akscr_pkg::sub_pos(mixed, 4'(i))];
		end
	end

	assign in_ready = !valid_s2 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (in_ready) begin
			valid_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s2 <= next;
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = data_s2;

endmodule
`default_nettype wire

### hdl/akscr_back.sv
`default_nettype none
// Stage 3: second permuted add, then third substitution.
module akscr_back (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire akscr_pkg::stage_t   in_data,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output akscr_pkg::stage_t        out_data
);

	logic              valid_s3;
	akscr_pkg::stage_t data_s3;
	akscr_pkg::stage_t next;
	akscr_pkg::idx_t   mixed;

	always_comb begin
		next.bad = in_data.bad;
		next.key = '0;
		mixed    = '0;
		for (int i = 0; i < akscr_pkg::KeyLen; i++) begin
			mixed = akscr_pkg::add_mod(in_data.key[i],
				in_data.key[akscr_pkg::PERM_B[i]]);
			next.key[i] = akscr_pkg::SUB_C[akscr_pkg::sub_pos(mixed, 4'(i))];
		end
	end

	assign in_ready = !valid_s3 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (in_ready) begin
			valid_s3 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s3 <= next;
		end
	end

	assign out_valid = valid_s3;
	assign out_data  = data_s3;

endmodule
`default_nettype wire

### hdl/auth_key_scramble_top.sv
// Key scrambler: maps a 16-character base-62 key to a scrambled key.
// Input channel in_valid/in_ready/in_data carries the key as two 64-bit
// words, character 0 in bits 7:0 of key_in_low. Output channel
// out_valid/out_ready/out_data returns the scrambled key in the same
// layout plus bad_character, set (with both key words zero) when any input
// byte lies outside '0'..'z'.
// Four register stages: decode and first table, first mix and second table,
// second mix and third table, then character encode into the output register.
// A key transferred in passes in order through stage 1, stage 2, stage 3
// and the output register before it shows on out_valid. One key per cycle
// is accepted in steady state while the receiver keeps out_ready high;
// every stage holds a valid bit and fills bubbles, so in_ready stays high
// while any stage has room.
// When the receiver stalls, results pile up stage by stage and in_ready
// drops once all four stages hold a key; nothing is dropped or repeated.
// Reset clears all valid bits; the pipeline comes up empty and ready.
`default_nettype none
module auth_key_scramble_top (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire akscr_pkg::in_t   in_data,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output akscr_pkg::out_t       out_data
);

	logic              v1, v2, v3;
	logic              r2, r3, r4;
	akscr_pkg::stage_t d1, d2, d3;
	logic              valid_s4;
	akscr_pkg::out_t   data_s4;
	akscr_pkg::out_t   next;
	logic [127:0]      enc;

	akscr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (v1),
		.out_ready (r2),
		.out_data  (d1)
	);

	akscr_mid u_mid (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v1),
		.in_ready  (r2),
		.in_data   (d1),
		.out_valid (v2),
		.out_ready (r3),
		.out_data  (d2)
	);

	akscr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v2),
		.in_ready  (r3),
		.in_data   (d2),
		.out_valid (v3),
		.out_ready (r4),
		.out_data  (d3)
	);

	always_comb begin
		enc = '0;
		for (int i = 0; i < akscr_pkg::KeyLen; i++) begin
			enc[8*i +: 8] = akscr_pkg::index_char(d3.key[i]);
		end
		if (d3.bad) begin
			enc = '0;
		end
		next.key_out_low   = enc[63:0];
		next.key_out_high  = enc[127:64];
		next.bad_character = d3.bad;
	end

	assign r4 = !valid_s4 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (r4) begin
			valid_s4 <= v3;
		end
	end

	always_ff @(posedge clk) begin
		if (v3 && r4) begin
			data_s4 <= next;
		end
	end

	assign out_valid = valid_s4;
	assign out_data  = data_s4;

	// a flagged key never leaks scrambled characters
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.bad_character |->
			out_data.key_out_low == 64'd0 && out_data.key_out_high == 64'd0)
		else $error("bad key produced nonzero output");

	// an empty output register means every upstream stage can move
	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled while output register empty");

	// a good key always encodes to alphabet characters; byte 0 of each word is checked never to fall below '0'
	a_good_encoded: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.bad_character |->
			out_data.key_out_low[7:0] >= 8'd48 && out_data.key_out_high[7:0] >= 8'd48)
		else $error("good key output outside alphabet");

	// a key leaving stage 3 lands in the output register on the next edge
	a_stage_move: assert property (@(posedge clk) disable iff (!arst_n)
		v3 && r4 |=> out_valid)
		else $error("stage 3 transfer lost");

endmodule
`default_nettype wire
